/* rtl/pvc_pkg.sv */
// shared types and constants of the peridynamic volume correction block
// used by the square root unit and the top level; no dependencies
package pvc_pkg;

   localparam int RAD_W      = 64;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int REM_W      = ROOT_W + 2;
   localparam int BITS_STEP  = 2;
   localparam int SQRT_ITERS = ROOT_W / BITS_STEP;
   localparam int ITER_W     = $clog2(SQRT_ITERS);

   typedef logic [RAD_W-1:0]  radicand_type;
   typedef logic [ROOT_W-1:0] root_type;
   typedef logic [REM_W-1:0]  remainder_type;

endpackage

/* rtl/pvc_sqrt.sv */
// iterative floor square root of a 64-bit value, two root bits per cycle
// depends on pvc_pkg for widths and types
module pvc_sqrt
   import pvc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  radicand_type radicand,
   output logic         done,
   output root_type     root
);

   localparam int TMP_W = REM_W + 2;

   radicand_type  rad_ff, rad_in;
   remainder_type rem_ff, rem_in;
   root_type      root_ff, root_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   always_comb begin
      logic [TMP_W-1:0] rem_t;
      logic [TMP_W-1:0] trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_t   = '0;
      trial   = '0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int k = 0; k < BITS_STEP; k++) begin
            rem_t = {rem_in, rad_in[RAD_W-1 -: 2]};
            rad_in = {rad_in[RAD_W-3:0], 2'b00};
            trial = {{(TMP_W-ROOT_W-2){1'b0}}, root_in, 2'b01};
            if (rem_t >= trial) begin
               rem_in  = REM_W'(rem_t - trial);
               root_in = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = REM_W'(rem_t);
               root_in = {root_in[ROOT_W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ITER_W'(SQRT_ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* rtl/peridynamic_volume_correction_top.sv */
// top level of the peridynamic partial volume correction block
// depends on pvc_pkg and pvc_sqrt
//
// usage: one transaction on the req_ stream carries one neighbor of the
// current node (offsets, nodal volume, tlast marks the final neighbor).
// each neighbor gives one transaction on the rsp_ stream with the
// correction factor and, on the final neighbor, the weighted volume sum
// with tlast set; the node sum is then cleared.
// one neighbor takes these steps from acceptance to the result register:
// the squares on the shared 32x32 multiplier for the squared length, the
// square root unit (two bits a cycle), then the correction multiply,
// saturation, the correction-volume product and four partial products of
// the 64x49 term, all multiplies on the same multiplier. req_tready is high only
// while the sequencer is idle, so no new neighbor is taken until the last one is done.
// the result sits in an output register; the next neighbor is accepted while
// it waits, and the sequencer holds in its last step if rsp_tready stays low.
// reset is synchronous: registers return to their defaults (horizon 1.0,
// spacing 1.0, inverse 1.0, tolerance one lsb), the sum clears and the
// output stream empties. csr writes belong between neighbors, while idle.
module peridynamic_volume_correction_top
   import pvc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // offset_x[31:0], offset_y[63:32], offset_z[95:64], nodal_volume[127:96]
   input  logic [127:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // correction[16:0], weighted_volume[80:17], zero fill[87:81]
   output logic [87:0]  rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic [1:0] REG_HORIZON = 2'd0;
   localparam logic [1:0] REG_SPACING = 2'd1;
   localparam logic [1:0] REG_INVERSE = 2'd2;
   localparam logic [1:0] REG_TOL     = 2'd3;

   localparam logic [16:0] ONE_Q16 = 17'd65536;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SQX  = 4'd1;
   localparam logic [3:0] S_SQY  = 4'd2;
   localparam logic [3:0] S_SQZ  = 4'd3;
   localparam logic [3:0] S_SQD  = 4'd4;
   localparam logic [3:0] S_ROOT = 4'd5;
   localparam logic [3:0] S_TEST = 4'd6;
   localparam logic [3:0] S_CMUL = 4'd7;
   localparam logic [3:0] S_CSAT = 4'd8;
   localparam logic [3:0] S_CV   = 4'd9;
   localparam logic [3:0] S_P00  = 4'd10;
   localparam logic [3:0] S_P01  = 4'd11;
   localparam logic [3:0] S_P10  = 4'd12;
   localparam logic [3:0] S_P11  = 4'd13;
   localparam logic [3:0] S_FIN  = 4'd14;
   localparam logic [3:0] S_DONE = 4'd15;

   logic [30:0] horizon_ff;
   logic [30:0] spacing_ff;
   logic [31:0] inverse_ff;
   logic [15:0] tol_ff;

   logic [3:0]   state_ff, state_in;
   logic [31:0]  mx_ff, my_ff, mz_ff, vol_ff;
   logic         last_ff;
   logic [63:0]  prod_ff, prod_in;
   logic [63:0]  sq_ff, sq_in;
   logic [63:0]  sq_sum;
   root_type     len_ff, len_in;
   logic         corrected_ff, corrected_in;
   logic         nonpos_ff, nonpos_in;
   logic [31:0]  num_ff, num_in;
   logic [16:0]  corr_ff, corr_in;
   logic [31:0]  cv_lo_ff, cv_lo_in;
   logic [16:0]  cv_hi_ff, cv_hi_in;
   logic [111:0] acc_ff, acc_in;
   logic [63:0]  vsum_ff, vsum_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [16:0]  rsp_corr_ff, rsp_corr_in;
   logic [63:0]  rsp_wv_ff, rsp_wv_in;
   logic         rsp_last_ff, rsp_last_in;

   logic [31:0]  mul_a, mul_b;
   logic         sqrt_start, sqrt_done;
   root_type     sqrt_root;
   logic         accept, csr_write, out_free;

   logic [29:0]  half_spacing;
   logic [33:0]  len_plus_r, h_plus_tol;
   logic [32:0]  h_plus_r;
   logic [63:0]  term;
   logic [64:0]  sum_wide;
   logic [63:0]  sum_sat;

   function automatic logic [31:0] magnitude(input logic [31:0] v);
      magnitude = v[31] ? (~v + 32'd1) : v;
   endfunction

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign half_spacing = spacing_ff[30:1];
   assign len_plus_r   = 34'(len_ff) + 34'(half_spacing);
   assign h_plus_tol   = 34'(horizon_ff) + 34'(tol_ff);
   assign h_plus_r     = 33'(horizon_ff) + 33'(half_spacing);
   assign sq_sum       = sq_ff + prod_ff;
   assign term         = acc_ff[111:48];
   assign sum_wide     = {1'b0, vsum_ff} + {1'b0, term};
   assign sum_sat      = sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];
   assign sqrt_start   = (state_ff == S_SQD);

   pvc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sq_sum),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   always_comb begin
      unique case (state_ff)
         S_SQX: begin
            mul_a = mx_ff;
            mul_b = mx_ff;
         end
         S_SQY: begin
            mul_a = my_ff;
            mul_b = my_ff;
         end
         S_SQZ: begin
            mul_a = mz_ff;
            mul_b = mz_ff;
         end
         S_CMUL: begin
            mul_a = num_ff;
            mul_b = inverse_ff;
         end
         S_CV: begin
            mul_a = {15'd0, corr_ff};
            mul_b = vol_ff;
         end
         S_P00: begin
            mul_a = sq_ff[31:0];
            mul_b = prod_ff[31:0];
         end
         S_P01: begin
            mul_a = sq_ff[31:0];
            mul_b = {15'd0, cv_hi_ff};
         end
         S_P10: begin
            mul_a = sq_ff[63:32];
            mul_b = cv_lo_ff;
         end
         S_P11: begin
            mul_a = sq_ff[63:32];
            mul_b = {15'd0, cv_hi_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      state_in     = state_ff;
      sq_in        = sq_ff;
      len_in       = len_ff;
      corrected_in = corrected_ff;
      nonpos_in    = nonpos_ff;
      num_in       = num_ff;
      corr_in      = corr_ff;
      cv_lo_in     = cv_lo_ff;
      cv_hi_in     = cv_hi_ff;
      acc_in       = acc_ff;
      vsum_in      = vsum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_corr_in  = rsp_corr_ff;
      rsp_wv_in    = rsp_wv_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_SQX;
         end
         S_SQX: state_in = S_SQY;
         S_SQY: begin
            sq_in    = prod_ff;
            state_in = S_SQZ;
         end
         S_SQZ: begin
            sq_in    = sq_sum;
            state_in = S_SQD;
         end
         S_SQD: begin
            sq_in    = sq_sum;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (sqrt_done) begin
               len_in   = sqrt_root;
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            corrected_in = len_plus_r > h_plus_tol;
            nonpos_in    = 33'(len_ff) >= h_plus_r;
            num_in       = 32'(h_plus_r - 33'(len_ff));
            state_in     = S_CMUL;
         end
         S_CMUL: state_in = S_CSAT;
         S_CSAT: begin
            priority if (!corrected_ff) begin
               corr_in = ONE_Q16;
            end else if (nonpos_ff) begin
               corr_in = '0;
            end else if (prod_ff[63:16] > 48'(ONE_Q16)) begin
               corr_in = ONE_Q16;
            end else begin
               corr_in = prod_ff[32:16];
            end
            state_in = S_CV;
         end
         S_CV: state_in = S_P00;
         S_P00: begin
            cv_lo_in = prod_ff[31:0];
            cv_hi_in = prod_ff[48:32];
            state_in = S_P01;
         end
         S_P01: begin
            acc_in   = {48'd0, prod_ff};
            state_in = S_P10;
         end
         S_P10: begin
            acc_in   = acc_ff + {16'd0, prod_ff, 32'd0};
            state_in = S_P11;
         end
         S_P11: begin
            acc_in   = acc_ff + {16'd0, prod_ff, 32'd0};
            state_in = S_FIN;
         end
         S_FIN: begin
            acc_in   = acc_ff + {prod_ff[47:0], 64'd0};
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_corr_in  = corr_ff;
               rsp_last_in  = last_ff;
               rsp_wv_in    = last_ff ? sum_sat : '0;
               vsum_in      = last_ff ? '0 : sum_sat;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mx_ff   <= magnitude(req_tdata[31:0]);
         my_ff   <= magnitude(req_tdata[63:32]);
         mz_ff   <= magnitude(req_tdata[95:64]);
         vol_ff  <= req_tdata[127:96];
         last_ff <= req_tlast;
      end
      prod_ff      <= prod_in;
      sq_ff        <= sq_in;
      len_ff       <= len_in;
      corrected_ff <= corrected_in;
      nonpos_ff    <= nonpos_in;
      num_ff       <= num_in;
      corr_ff      <= corr_in;
      cv_lo_ff     <= cv_lo_in;
      cv_hi_ff     <= cv_hi_in;
      acc_ff       <= acc_in;
      rsp_corr_ff  <= rsp_corr_in;
      rsp_wv_ff    <= rsp_wv_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         vsum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vsum_ff      <= vsum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         horizon_ff <= 31'd65536;
         spacing_ff <= 31'd65536;
         inverse_ff <= 32'd65536;
         tol_ff     <= 16'd1;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_HORIZON: horizon_ff <= csr_pwdata[30:0];
            REG_SPACING: spacing_ff <= csr_pwdata[30:0];
            REG_INVERSE: inverse_ff <= csr_pwdata;
            REG_TOL:     tol_ff     <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_HORIZON: csr_prdata = {1'b0, horizon_ff};
         REG_SPACING: csr_prdata = {1'b0, spacing_ff};
         REG_INVERSE: csr_prdata = inverse_ff;
         REG_TOL:     csr_prdata = {16'd0, tol_ff};
         default:     csr_prdata = '0;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_wv_ff, rsp_corr_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* tb/tb_top.sv */
// testbench of peridynamic_volume_correction_top: a directed table of bonds and register
// writes, then random neighbor lists under several register settings, checked against known
// values or a bond predictor; depends only on the rtl of the block
module tb_top;

   localparam int     CLOCK_HIGH   = 6;
   localparam int     CLOCK_LOW    = 6;
   localparam int     CYCLE_LIMIT  = 600000;
   localparam int     NUM_PHASES   = 12;
   localparam int     FIXED_PHASES = 8;
   localparam int     PHASE_ITEMS  = 115;
   localparam int     DRAIN_CYCLES = 40;
   localparam int     REPORT_LIMIT = 10;
   localparam longint COORD_MAX    = 2147483647;
   localparam logic [16:0] ONE_Q16 = 17'h1_0000;

   typedef enum logic [1:0] {
      REG_HORIZON, REG_SPACING, REG_INVERSE, REG_TOLERANCE
   } csr_index_type;
   typedef enum logic {ROW_NEIGHBOR, ROW_WRITE} row_kind_type;

   typedef struct packed {
      logic [31:0] offset_x;
      logic [31:0] offset_y;
      logic [31:0] offset_z;
      logic [31:0] nodal_volume;
      logic        last_neighbor;
   } neighbor_type;

   typedef struct packed {
      logic [16:0] correction;
      logic [63:0] weighted_volume;
      logic        node_done;
   } bond_result_type;

   typedef struct packed {
      row_kind_type  kind;
      csr_index_type reg_sel;
      logic [31:0]   reg_value;
      neighbor_type  item;
      logic          typed;
      logic [16:0]   correction;
      logic [63:0]   weighted_volume;
   } plan_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // offset_x[31:0], offset_y[63:32], offset_z[95:64], nodal_volume[127:96]
   logic [127:0] req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   // correction[16:0], weighted_volume[80:17], zero fill[87:81]
   logic [87:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   logic [30:0]  cfg_horizon = 31'h1_0000;
   logic [30:0]  cfg_spacing = 31'h1_0000;
   logic [31:0]  cfg_inverse = 32'h1_0000;
   logic [15:0]  cfg_tolerance = 16'd1;
   logic [63:0]  node_sum = '0;

   bond_result_type pending [$];
   bond_result_type rsp_want;
   plan_row_type    directed_plan [$];
   int              error_count = 0;
   int unsigned     cycle_count = 0;
   int              stall_left = 0;
   bit              gaps_on = 1'b1;
   bit              stall_on = 1'b1;

   logic [31:0] set_horizon [FIXED_PHASES] = '{32'h0001_0000, 32'h0003_0000, 32'h0002_8000,
      32'h0000_0000, 32'hFFFF_FFFF, 32'h0005_0000, 32'h0002_0000, 32'h0001_8000};
   logic [31:0] set_spacing [FIXED_PHASES] = '{32'h0001_0000, 32'h0001_0000, 32'h0000_8000,
      32'h0000_0001, 32'h7FFF_FFFF, 32'h0002_0000, 32'h0000_0000, 32'h0001_4000};
   logic [31:0] set_inverse [FIXED_PHASES] = '{32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
      32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 32'h0001_0000, 32'h0000_CCCD};
   logic [31:0] set_tolerance [FIXED_PHASES] = '{32'd1, 32'd0, 32'h0000_FFFF, 32'd0,
      32'hFFFF_FFFF, 32'd100, 32'hABCD_0001, 32'd16};

   peridynamic_volume_correction_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #CLOCK_LOW clock = 1'b1;
      #CLOCK_HIGH clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic void flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("mismatch in %s: expected %h, got %h", what, want, got);
   endfunction

   function automatic logic [63:0] magnitude(logic [31:0] v);
      return v[31] ? 64'h1_0000_0000 - {32'd0, v} : {32'd0, v};
   endfunction

   // bond length, boundary correction and saturating node sum
   function automatic bond_result_type predict_bond(neighbor_type n);
      logic [63:0]  mag_x, mag_y, mag_z, sq_len, root, trial, scaled, corr_vol, num_u;
      logic [127:0] wide;
      logic [64:0]  total;
      longint       bond_len, half_dx, reach, num;
      logic [16:0]  corr;
      bond_result_type res;
      mag_x = magnitude(n.offset_x);
      mag_y = magnitude(n.offset_y);
      mag_z = magnitude(n.offset_z);
      sq_len = mag_x * mag_x + mag_y * mag_y + mag_z * mag_z;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= sq_len)
            root = trial;
      end
      bond_len = longint'(root);
      half_dx = longint'(cfg_spacing >> 1);
      reach = longint'(cfg_horizon);
      corr = ONE_Q16;
      if (bond_len - (reach - half_dx) > longint'(cfg_tolerance)) begin
         num = reach + half_dx - bond_len;
         if (num <= 0) begin
            corr = '0;
         end else begin
            num_u = num;
            scaled = (num_u * {32'd0, cfg_inverse}) >> 16;
            corr = (scaled > {47'd0, ONE_Q16}) ? ONE_Q16 : scaled[16:0];
         end
      end
      corr_vol = {47'd0, corr} * {32'd0, n.nodal_volume};
      wide = {64'd0, sq_len} * {64'd0, corr_vol};
      total = {1'b0, node_sum} + {1'b0, wide[111:48]};
      if (total[64])
         total[63:0] = '1;
      res.correction = corr;
      res.node_done = n.last_neighbor;
      if (n.last_neighbor) begin
         res.weighted_volume = total[63:0];
         node_sum = '0;
      end else begin
         res.weighted_volume = '0;
         node_sum = total[63:0];
      end
      return res;
   endfunction

   function automatic plan_row_type bond_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                             logic [31:0] vol, logic last);
      plan_row_type row;
      row = '0;
      row.kind = ROW_NEIGHBOR;
      row.item = '{x, y, z, vol, last};
      return row;
   endfunction

   function automatic plan_row_type known_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                              logic [31:0] vol, logic last,
                                              logic [16:0] corr, logic [63:0] wv);
      plan_row_type row;
      row = bond_row(x, y, z, vol, last);
      row.typed = 1'b1;
      row.correction = corr;
      row.weighted_volume = wv;
      return row;
   endfunction

   function automatic plan_row_type write_row(csr_index_type sel, logic [31:0] value);
      plan_row_type row;
      row = '0;
      row.kind = ROW_WRITE;
      row.reg_sel = sel;
      row.reg_value = value;
      return row;
   endfunction

   task automatic write_reg(csr_index_type sel, logic [31:0] value);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {sel, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (sel)
         REG_HORIZON:   cfg_horizon = value[30:0];
         REG_SPACING:   cfg_spacing = value[30:0];
         REG_INVERSE:   cfg_inverse = value;
         REG_TOLERANCE: cfg_tolerance = value[15:0];
      endcase
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic check_reg(csr_index_type sel);
      logic [31:0] want;
      case (sel)
         REG_HORIZON:   want = {1'b0, cfg_horizon};
         REG_SPACING:   want = {1'b0, cfg_spacing};
         REG_INVERSE:   want = cfg_inverse;
         REG_TOLERANCE: want = {16'd0, cfg_tolerance};
      endcase
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = {sel, 2'b00};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata != want)
         flag_mismatch("register readback", {32'd0, want}, {32'd0, csr_prdata});
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic push_neighbor(neighbor_type n, logic typed, logic [16:0] corr,
                                logic [63:0] wv);
      bond_result_type res;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {n.nodal_volume, n.offset_z, n.offset_y, n.offset_x};
      req_tlast = n.last_neighbor;
      do @(posedge clock); while (!req_tready);
      res = predict_bond(n);
      if (typed) begin
         res.correction = corr;
         res.weighted_volume = wv;
      end
      pending.push_back(res);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (stall_left == 0 && stall_on && $urandom_range(0, 4) == 0)
         stall_left = $urandom_range(1, 9);
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending.size() == 0) begin
            flag_mismatch("transaction with nothing expected", '0, rsp_tdata[80:17]);
         end else begin
            rsp_want = pending.pop_front();
            if (rsp_tdata[16:0] != rsp_want.correction)
               flag_mismatch("correction", {47'd0, rsp_want.correction},
                             {47'd0, rsp_tdata[16:0]});
            if (rsp_tdata[80:17] != rsp_want.weighted_volume)
               flag_mismatch("weighted volume", rsp_want.weighted_volume, rsp_tdata[80:17]);
            if (rsp_tlast != rsp_want.node_done)
               flag_mismatch("node done", {63'd0, rsp_want.node_done}, {63'd0, rsp_tlast});
            if (rsp_tdata[87:81] != '0)
               flag_mismatch("zero fill", '0, {57'd0, rsp_tdata[87:81]});
         end
      end
   end

   initial begin
      plan_row_type row;
      neighbor_type item;
      logic [31:0]  ph_h, ph_dx, ph_inv, ph_tol;
      logic [63:0]  inv_wide;
      logic [31:0]  comp_val [3];
      longint       boundary, lo, hi, span;
      int           pick, axis;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int s = 0; s < 4; s++)
         check_reg(csr_index_type'(s));

      // defaults: horizon 1.0, spacing 1.0, inverse 1.0, tolerance one lsb
      directed_plan.push_back(known_row(32'h0, 32'h0, 32'h0, 32'h0, 1'b1, ONE_Q16, 64'd0));
      directed_plan.push_back(known_row(32'h1_0000, 32'h0, 32'h0, 32'h1_0000, 1'b1,
                                        17'h8000, 64'h8000));
      directed_plan.push_back(known_row(32'h8000, 32'h0, 32'h0, 32'h1_0000, 1'b1,
                                        ONE_Q16, 64'h4000));
      directed_plan.push_back(bond_row(32'h8001, 32'h0, 32'h0, 32'h1_0000, 1'b0));
      directed_plan.push_back(bond_row(32'h0, 32'h8002, 32'h0, 32'h1_0000, 1'b0));
      directed_plan.push_back(bond_row(32'h0, 32'h0, 32'hFFFF_8000, 32'h2_0000, 1'b1));
      directed_plan.push_back(known_row(32'h1_8000, 32'h0, 32'h0, 32'h1_0000, 1'b1,
                                        17'd0, 64'd0));
      directed_plan.push_back(known_row(32'h8000_0000, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0,
                                        17'd0, 64'd0));
      directed_plan.push_back(known_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'hFFFF_FFFF, 1'b1, 17'd0, 64'd0));
      directed_plan.push_back(bond_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFF, 1'b1));
      directed_plan.push_back(bond_row(32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000,
                                       32'h1_0000, 1'b1));
      // high bits of the tolerance are dropped
      directed_plan.push_back(write_row(REG_TOLERANCE, 32'hFFFF_0000));
      directed_plan.push_back(bond_row(32'h8001, 32'h0, 32'h0, 32'h1_0000, 1'b1));
      // zero reciprocal
      directed_plan.push_back(write_row(REG_INVERSE, 32'h0));
      directed_plan.push_back(known_row(32'h1_0000, 32'h0, 32'h0, 32'h1_0000, 1'b1,
                                        17'd0, 64'd0));
      directed_plan.push_back(write_row(REG_INVERSE, 32'hFFFF_FFFF));
      directed_plan.push_back(known_row(32'h1_0000, 32'h0, 32'h0, 32'h1_0000, 1'b1,
                                        ONE_Q16, 64'h1_0000));
      // zero spacing, reached through the masked top bit
      directed_plan.push_back(write_row(REG_SPACING, 32'h8000_0000));
      directed_plan.push_back(known_row(32'h1_0000, 32'h0, 32'h0, 32'h1_0000, 1'b1,
                                        ONE_Q16, 64'h1_0000));
      directed_plan.push_back(known_row(32'h1_0001, 32'h0, 32'h0, 32'h1_0000, 1'b1,
                                        17'd0, 64'd0));
      // largest horizon, then drive the node sum into saturation
      directed_plan.push_back(write_row(REG_HORIZON, 32'hFFFF_FFFF));
      directed_plan.push_back(write_row(REG_SPACING, 32'h1_0000));
      for (int k = 0; k < 5; k++)
         directed_plan.push_back(known_row(32'h4000_0000, 32'h4000_0000, 32'h4000_0000,
                                           32'hFFFF_FFFF, 1'b0, ONE_Q16, 64'd0));
      directed_plan.push_back(known_row(32'h4000_0000, 32'h4000_0000, 32'h4000_0000,
                                        32'hFFFF_FFFF, 1'b1, ONE_Q16, '1));
      directed_plan.push_back(known_row(32'h0, 32'h0, 32'h0, 32'h0, 1'b1, ONE_Q16, 64'd0));

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.kind == ROW_WRITE) begin
            wait_drained();
            write_reg(row.reg_sel, row.reg_value);
            check_reg(row.reg_sel);
         end else begin
            push_neighbor(row.item, row.typed, row.correction, row.weighted_volume);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph < FIXED_PHASES) begin
            ph_h = set_horizon[ph];
            ph_dx = set_spacing[ph];
            ph_inv = set_inverse[ph];
            ph_tol = set_tolerance[ph];
         end else begin
            ph_h = $urandom_range(0, 32'h0010_0000);
            ph_dx = $urandom_range(1, 32'h0004_0000);
            inv_wide = 64'h1_0000_0000 / {32'd0, ph_dx};
            ph_inv = (inv_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : inv_wide[31:0];
            ph_tol = $urandom_range(0, 255);
         end
         wait_drained();
         write_reg(REG_HORIZON, ph_h);
         write_reg(REG_SPACING, ph_dx);
         write_reg(REG_INVERSE, ph_inv);
         write_reg(REG_TOLERANCE, ph_tol);
         for (int s = 0; s < 4; s++)
            check_reg(csr_index_type'(s));
         gaps_on = (ph != NUM_PHASES - 1) && (ph % 3 != 2);
         stall_on = gaps_on;

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            boundary = longint'(cfg_horizon) - longint'(cfg_spacing >> 1)
                       + longint'(cfg_tolerance);
            for (int a = 0; a < 3; a++)
               comp_val[a] = '0;
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               // one axis near the correction boundary
               axis = $urandom_range(0, 2);
               if ($urandom_range(0, 1)) begin
                  lo = boundary - 8;
                  hi = boundary + 8;
               end else begin
                  lo = boundary - longint'(cfg_spacing);
                  hi = longint'(cfg_horizon) + longint'(cfg_spacing);
               end
               if (lo < 0) lo = 0;
               if (hi < 0) hi = 0;
               if (hi > COORD_MAX) hi = COORD_MAX;
               if (lo > hi) lo = hi;
               span = lo + longint'($urandom_range(0, 32'(hi - lo)));
               comp_val[axis] = $urandom_range(0, 1) ? 32'(-span) : 32'(span);
               for (int a = 0; a < 3; a++)
                  if (a != axis && $urandom_range(0, 2) == 0)
                     comp_val[a] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
            end else if (pick < 80) begin
               span = (longint'(cfg_horizon) + longint'(cfg_spacing)) * 3 / 5 + 1;
               if (span > COORD_MAX) span = COORD_MAX;
               for (int a = 0; a < 3; a++)
                  comp_val[a] = 32'(longint'($urandom_range(0, 32'(2 * span))) - span);
            end else if (pick < 93) begin
               for (int a = 0; a < 3; a++)
                  comp_val[a] = $urandom;
            end else begin
               for (int a = 0; a < 3; a++)
                  case ($urandom_range(0, 4))
                     0:       comp_val[a] = 32'h0;
                     1:       comp_val[a] = 32'h7FFF_FFFF;
                     2:       comp_val[a] = 32'h8000_0000;
                     3:       comp_val[a] = 32'hFFFF_FFFF;
                     default: comp_val[a] = $urandom_range(0, 255);
                  endcase
            end
            item.offset_x = comp_val[0];
            item.offset_y = comp_val[1];
            item.offset_z = comp_val[2];
            pick = $urandom_range(0, 9);
            if (pick < 5)
               item.nodal_volume = $urandom;
            else if (pick < 8)
               item.nodal_volume = $urandom_range(0, 32'h2_0000);
            else if (pick == 8)
               item.nodal_volume = 32'h0;
            else
               item.nodal_volume = 32'hFFFF_FFFF;
            item.last_neighbor = ($urandom_range(0, 5) == 0);
            push_neighbor(item, 1'b0, '0, '0);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
